// ----- rtl/core/rtor_pkg.sv -----
// Shared constants, types and codes for the scanner and device RSSI table.
`timescale 1ns / 1ps
package rtor_pkg;

   localparam int MAX_SCANNERS  = 8;
   localparam int TABLE_ENTRIES = 32;

   localparam int SLOT_W  = (MAX_SCANNERS > 1) ? $clog2(MAX_SCANNERS) : 1;
   localparam int ENTRY_W = $clog2(TABLE_ENTRIES);
   localparam int COUNT_W = $clog2(MAX_SCANNERS + 1);

   localparam int MAC_W  = 48;
   localparam int CONN_W = 16;
   localparam int HDR_W  = 22;
   localparam int TIME_W = 32;
   localparam int RSSI_W = 8;

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 16;
   localparam int OUT_ENTRY_W = 5;
   localparam int OUT_SLOT_W  = 3;
   localparam int OUT_COUNT_W = 4;

   localparam int SLOT_RAM_DEPTH = TABLE_ENTRIES * (1 << SLOT_W);

   typedef enum logic [1:0] {
      FUNC_ADD,
      FUNC_REMOVE,
      FUNC_RPT_CONN,
      FUNC_RPT_MAC
   } func_type;

   typedef enum logic [2:0] {
      ST_UPDATED,
      ST_REPLACED,
      ST_ADDED,
      ST_SCAN_UPDATED,
      ST_FULL,
      ST_REMOVED,
      ST_NOT_FOUND
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SWEEP,
      S_WRITE,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [MAC_W-1:0]        mac;
      logic [HDR_W-1:0]        hdr;
      logic [TIME_W-1:0]       tstamp;
      logic [COUNT_W-1:0]      count;
      logic [MAX_SCANNERS-1:0] mask;
   } dev_row_type;

   localparam int ROW_W = $bits(dev_row_type);

   typedef struct packed {
      logic              add_en;
      logic              upd_en;
      logic              rem_en;
      logic [SLOT_W-1:0] slot;
      logic [MAC_W-1:0]  mac;
      logic [CONN_W-1:0] conn;
   } scan_ctrl_type;

   typedef struct packed {
      logic              full;
      logic [SLOT_W-1:0] free_slot;
      logic              mac_hit;
      logic [SLOT_W-1:0] mac_slot;
      logic              conn_hit;
      logic [SLOT_W-1:0] conn_slot;
   } scan_stat_type;

endpackage

// ----- rtl/core/rssi_table_oldest_replace_unit.sv -----
// Top level: request decode, device table sweep and result register.
//
// Scanner operations (add, update, full) pass from the decide state through the
// result registers into the output register. A remove and a report
// sweep the device table memory one entry per cycle through its single read
// port. A report adds the write-back state after the sweep. A new request is
// taken in the cycle after the previous one has placed its result in the output
// register, and that result may still wait there.
`timescale 1ns / 1ps
module rssi_table_oldest_replace_unit
   import rtor_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // scanner_mac[47:0], conn_id[63:48], device_mac[111:64], rssi[119:112],
   // timestamp[151:120], adv_flags[159:152], adv_len[165:160],
   // event_type[173:166], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entry_index[4:0], scanner_slot[7:5], valid_count[11:8], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]            rsp_tuser
);

   state_type state_ff, state_in;

   func_type          func_ff;
   logic [MAC_W-1:0]  smac_ff;
   logic [CONN_W-1:0] conn_ff;
   logic [MAC_W-1:0]  dmac_ff;
   logic [RSSI_W-1:0] rssi_ff;
   logic [TIME_W-1:0] time_ff;
   logic [HDR_W-1:0]  hdr_ff;

   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [ENTRY_W:0]   rd_idx_ff, rd_idx_in;
   logic               q_vld_ff, q_vld_in;
   logic [ENTRY_W-1:0] q_idx_ff;
   logic               hit_ff, hit_in;
   logic [ENTRY_W-1:0] hit_idx_ff, hit_idx_in;
   dev_row_type        hit_row_ff, hit_row_in;
   logic [ENTRY_W-1:0] best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]  best_time_ff, best_time_in;
   logic [TABLE_ENTRIES-1:0] row_vld_ff, row_vld_in;

   status_type             res_status_ff, res_status_in;
   logic [OUT_ENTRY_W-1:0] res_entry_ff, res_entry_in;
   logic [OUT_SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [OUT_COUNT_W-1:0] res_count_ff, res_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   scan_ctrl_type scan_ctrl;
   scan_stat_type scan_stat;

   logic               dev_rd_en;
   logic [ENTRY_W-1:0] dev_rd_addr;
   logic [ROW_W-1:0]   dev_rd_data;
   logic               dev_we;
   logic [ENTRY_W-1:0] dev_waddr;
   dev_row_type        dev_wdata;
   dev_row_type        row_q;

   logic                          slot_we;
   logic [ENTRY_W+SLOT_W-1:0]     slot_addr;
   logic [RSSI_W+TIME_W-1:0]      slot_rd_unused;

   logic                    req_take;
   logic                    found;
   logic [SLOT_W-1:0]       found_slot;
   logic [MAX_SCANNERS-1:0] slot_bit;

   rtor_scan_table u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .look_mac  (smac_ff),
      .look_conn (conn_ff),
      .stat      (scan_stat)
   );

   rtor_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_dev_ram (
      .clock   (clock),
      .wr_en   (dev_we),
      .wr_addr (dev_waddr),
      .wr_data (dev_wdata),
      .rd_en   (dev_rd_en),
      .rd_addr (dev_rd_addr),
      .rd_data (dev_rd_data)
   );

   rtor_ram #(.WIDTH(RSSI_W + TIME_W), .DEPTH(SLOT_RAM_DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_addr),
      .wr_data ({rssi_ff, time_ff}),
      .rd_en   (1'b0),
      .rd_addr (slot_addr),
      .rd_data (slot_rd_unused)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign found      = (func_ff == FUNC_RPT_MAC) ? scan_stat.mac_hit : scan_stat.conn_hit;
   assign found_slot = (func_ff == FUNC_RPT_MAC) ? scan_stat.mac_slot : scan_stat.conn_slot;
   assign slot_bit   = MAX_SCANNERS'(1) << slot_ff;
   assign row_q      = row_vld_ff[q_idx_ff] ? dev_row_type'(dev_rd_data) : '0;
   assign dev_rd_addr = rd_idx_ff[ENTRY_W-1:0];
   assign slot_addr   = {dev_waddr, slot_ff};

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      rd_idx_in     = rd_idx_ff;
      q_vld_in      = 1'b0;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_row_in    = hit_row_ff;
      best_idx_in   = best_idx_ff;
      best_time_in  = best_time_ff;
      row_vld_in    = row_vld_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      res_slot_in   = res_slot_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      scan_ctrl     = '0;
      scan_ctrl.mac = smac_ff;
      scan_ctrl.conn = conn_ff;
      dev_rd_en     = 1'b0;
      dev_we        = 1'b0;
      dev_waddr     = q_idx_ff;
      dev_wdata     = row_q;
      slot_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_entry_in = '0;
            res_count_in = '0;
            res_slot_in  = '0;
            state_in     = S_RESULT;
            if (func_ff == FUNC_ADD) begin
               if (scan_stat.full) begin
                  res_status_in = ST_FULL;
               end else if (scan_stat.mac_hit) begin
                  scan_ctrl.upd_en = 1'b1;
                  scan_ctrl.slot   = scan_stat.mac_slot;
                  res_status_in    = ST_SCAN_UPDATED;
                  res_slot_in      = OUT_SLOT_W'(scan_stat.mac_slot);
               end else begin
                  scan_ctrl.add_en = 1'b1;
                  scan_ctrl.slot   = scan_stat.free_slot;
                  res_status_in    = ST_ADDED;
                  res_slot_in      = OUT_SLOT_W'(scan_stat.free_slot);
               end
            end else if (!found) begin
               res_status_in = ST_NOT_FOUND;
            end else begin
               slot_in   = found_slot;
               rd_idx_in = '0;
               hit_in    = 1'b0;
               state_in  = S_SWEEP;
               if (func_ff == FUNC_REMOVE) begin
                  scan_ctrl.rem_en = 1'b1;
                  scan_ctrl.slot   = found_slot;
               end
            end
         end
         S_SWEEP: begin
            if (rd_idx_ff < (ENTRY_W+1)'(TABLE_ENTRIES)) begin
               dev_rd_en = 1'b1;
               q_vld_in  = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (q_vld_ff) begin
               if (func_ff == FUNC_REMOVE) begin
                  if (row_q.mask[slot_ff]) begin
                     dev_we = 1'b1;
                     dev_wdata.mask = row_q.mask & ~slot_bit;
                     if (row_q.count != '0) begin
                        dev_wdata.count = row_q.count - 1'b1;
                     end
                  end
               end else begin
                  if (!hit_ff && row_q.count != '0 && row_q.mac == dmac_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = q_idx_ff;
                     hit_row_in = row_q;
                  end
                  if (q_idx_ff == '0 || row_q.tstamp < best_time_ff) begin
                     best_idx_in  = q_idx_ff;
                     best_time_in = row_q.tstamp;
                  end
               end
               if (q_idx_ff == ENTRY_W'(TABLE_ENTRIES - 1)) begin
                  if (func_ff == FUNC_REMOVE) begin
                     res_status_in = ST_REMOVED;
                     res_entry_in  = '0;
                     res_slot_in   = OUT_SLOT_W'(slot_ff);
                     res_count_in  = '0;
                     state_in      = S_RESULT;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
            end
         end
         S_WRITE: begin
            dev_we      = 1'b1;
            slot_we     = 1'b1;
            res_slot_in = OUT_SLOT_W'(slot_ff);
            if (hit_ff) begin
               dev_waddr        = hit_idx_ff;
               dev_wdata        = hit_row_ff;
               dev_wdata.tstamp = time_ff;
               dev_wdata.mask   = hit_row_ff.mask | slot_bit;
               if (!hit_row_ff.mask[slot_ff]) begin
                  dev_wdata.count = hit_row_ff.count + 1'b1;
               end
               res_status_in = ST_UPDATED;
               res_entry_in  = OUT_ENTRY_W'(hit_idx_ff);
               res_count_in  = OUT_COUNT_W'(dev_wdata.count);
            end else begin
               dev_waddr        = best_idx_ff;
               dev_wdata.mac    = dmac_ff;
               dev_wdata.hdr    = hdr_ff;
               dev_wdata.tstamp = time_ff;
               dev_wdata.count  = COUNT_W'(1);
               dev_wdata.mask   = slot_bit;
               res_status_in    = ST_REPLACED;
               res_entry_in     = OUT_ENTRY_W'(best_idx_ff);
               res_count_in     = OUT_COUNT_W'(1);
            end
            row_vld_in[dev_waddr] = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         q_vld_ff     <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_vld_ff   <= row_vld_in;
         q_vld_ff     <= q_vld_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= func_type'(req_tuser);
         smac_ff <= req_tdata[47:0];
         conn_ff <= req_tdata[63:48];
         dmac_ff <= req_tdata[111:64];
         rssi_ff <= req_tdata[119:112];
         time_ff <= req_tdata[151:120];
         hdr_ff  <= req_tdata[173:152];
      end
      slot_ff       <= slot_in;
      rd_idx_ff     <= rd_idx_in;
      q_idx_ff      <= rd_idx_ff[ENTRY_W-1:0];
      hit_idx_ff    <= hit_idx_in;
      hit_row_ff    <= hit_row_in;
      best_idx_ff   <= best_idx_in;
      best_time_ff  <= best_time_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      res_slot_ff   <= res_slot_in;
      res_count_ff  <= res_count_in;
      if (state_ff == S_RESULT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= {4'b0, res_count_ff, res_slot_ff, res_entry_ff};
      end
   end

endmodule

// ----- rtl/core/rtor_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rtor_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rtor_scan_table.sv -----
// Scanner table: MAC, connection id and used bit per scanner slot, with lookups.
`timescale 1ns / 1ps
module rtor_scan_table
   import rtor_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  scan_ctrl_type ctrl,
   input  logic [MAC_W-1:0]  look_mac,
   input  logic [CONN_W-1:0] look_conn,
   output scan_stat_type stat
);

   logic [MAC_W-1:0]        mac_ff  [MAX_SCANNERS];
   logic [CONN_W-1:0]       conn_ff [MAX_SCANNERS];
   logic [MAX_SCANNERS-1:0] used_ff;
   logic [MAX_SCANNERS-1:0] used_in;

   always_comb begin
      used_in = used_ff;
      if (ctrl.add_en) begin
         used_in[ctrl.slot] = 1'b1;
      end
      if (ctrl.rem_en) begin
         used_in[ctrl.slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_SCANNERS; s++) begin
            mac_ff[s]  <= '0;
            conn_ff[s] <= '0;
         end
      end else begin
         if (ctrl.add_en) begin
            mac_ff[ctrl.slot] <= ctrl.mac;
         end
         if (ctrl.add_en || ctrl.upd_en) begin
            conn_ff[ctrl.slot] <= ctrl.conn;
         end
      end
   end

   always_comb begin
      stat.full      = &used_ff;
      stat.free_slot = '0;
      stat.mac_hit   = 1'b0;
      stat.mac_slot  = '0;
      stat.conn_hit  = 1'b0;
      stat.conn_slot = '0;
      for (int s = MAX_SCANNERS - 1; s >= 0; s--) begin
         if (!used_ff[s]) begin
            stat.free_slot = SLOT_W'(s);
         end
         if (used_ff[s] && mac_ff[s] == look_mac) begin
            stat.mac_hit  = 1'b1;
            stat.mac_slot = SLOT_W'(s);
         end
         if (used_ff[s] && conn_ff[s] == look_conn) begin
            stat.conn_hit  = 1'b1;
            stat.conn_slot = SLOT_W'(s);
         end
      end
   end

endmodule

// ----- bench/tb_rssi_table_oldest_replace_unit.sv -----
// Self-checking regression bench for the scanner and device RSSI table.
`timescale 1ns / 1ps
module tb_rssi_table_oldest_replace_unit
   import rtor_pkg::*;
;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] entry;
      logic [2:0] slot;
      logic [3:0] count;
   } table_result_type;

   class rssi_table_scoreboard;
      logic [47:0] scn_mac[MAX_SCANNERS];
      logic [15:0] scn_conn[MAX_SCANNERS];
      bit          scn_used[MAX_SCANNERS];
      logic [47:0] dv_mac[TABLE_ENTRIES];
      logic [31:0] dv_time[TABLE_ENTRIES];
      int          dv_count[TABLE_ENTRIES];
      bit          dv_slot[TABLE_ENTRIES][MAX_SCANNERS];
      table_result_type pending_results[$];
      int          mismatches;

      function void clear();
         for (int s = 0; s < MAX_SCANNERS; s++) begin
            scn_mac[s] = '0; scn_conn[s] = '0; scn_used[s] = 0;
         end
         for (int e = 0; e < TABLE_ENTRIES; e++) begin
            dv_mac[e] = '0; dv_time[e] = '0; dv_count[e] = 0;
            for (int s = 0; s < MAX_SCANNERS; s++) dv_slot[e][s] = 0;
         end
         pending_results.delete();
         mismatches = 0;
      endfunction

      function int scanner_by_conn(logic [15:0] id);
         for (int s = 0; s < MAX_SCANNERS; s++)
            if (scn_used[s] && scn_conn[s] == id) return s;
         return -1;
      endfunction

      function int scanner_by_mac(logic [47:0] mac);
         for (int s = 0; s < MAX_SCANNERS; s++)
            if (scn_used[s] && scn_mac[s] == mac) return s;
         return -1;
      endfunction

      function void note_request(func_type fn, logic [47:0] smac, logic [15:0] conn,
                                 logic [47:0] dmac, logic [31:0] now);
         table_result_type r;
         int s, e, nused;
         r = '0;
         nused = 0;
         if (fn == FUNC_ADD) begin
            for (int i = 0; i < MAX_SCANNERS; i++) nused += scn_used[i];
            if (nused >= MAX_SCANNERS) r.status = ST_FULL;
            else begin
               s = scanner_by_mac(smac);
               if (s >= 0) begin
                  scn_conn[s] = conn; r.status = ST_SCAN_UPDATED; r.slot = 3'(s);
               end else begin
                  for (s = 0; s < MAX_SCANNERS; s++) if (!scn_used[s]) break;
                  scn_used[s] = 1; scn_mac[s] = smac; scn_conn[s] = conn;
                  r.status = ST_ADDED; r.slot = 3'(s);
               end
            end
         end else if (fn == FUNC_REMOVE) begin
            s = scanner_by_conn(conn);
            if (s < 0) r.status = ST_NOT_FOUND;
            else begin
               scn_used[s] = 0;
               for (e = 0; e < TABLE_ENTRIES; e++)
                  if (dv_slot[e][s]) begin
                     dv_slot[e][s] = 0;
                     if (dv_count[e] > 0) dv_count[e]--;
                  end
               r.status = ST_REMOVED; r.slot = 3'(s);
            end
         end else begin
            s = (fn == FUNC_RPT_CONN) ? scanner_by_conn(conn) : scanner_by_mac(smac);
            if (s < 0) r.status = ST_NOT_FOUND;
            else begin
               for (e = 0; e < TABLE_ENTRIES; e++)
                  if (dv_count[e] > 0 && dv_mac[e] == dmac) break;
               if (e < TABLE_ENTRIES) begin
                  if (!dv_slot[e][s]) begin
                     dv_slot[e][s] = 1; dv_count[e]++;
                  end
                  dv_time[e] = now;
                  r.status = ST_UPDATED;
               end else begin
                  e = 0;
                  for (int i = 1; i < TABLE_ENTRIES; i++)
                     if (dv_time[i] < dv_time[e]) e = i;
                  dv_mac[e] = dmac;
                  for (int i = 0; i < MAX_SCANNERS; i++) dv_slot[e][i] = 0;
                  dv_slot[e][s] = 1; dv_count[e] = 1; dv_time[e] = now;
                  r.status = ST_REPLACED;
               end
               r.entry = 5'(e); r.slot = 3'(s); r.count = 4'(dv_count[e]);
            end
         end
         pending_results = {pending_results, r};
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(table_result_type got);
         table_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
         end
         want = pending_results.pop_front();
         if (got.status != want.status)
            report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
         if (got.entry != want.entry)
            report_mismatch($sformatf("entry %0d want %0d", got.entry, want.entry));
         if (got.slot != want.slot)
            report_mismatch($sformatf("slot %0d want %0d", got.slot, want.slot));
         if (got.count != want.count)
            report_mismatch($sformatf("count %0d want %0d", got.count, want.count));
      endtask
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0] rsp_tuser;

   rssi_table_oldest_replace_unit dut (.*);

   rssi_table_scoreboard board;
   int send_idle_pct, recv_stall_pct;
   logic [47:0] known_smac[4];
   logic [15:0] known_conn[4];
   logic [47:0] known_dmac[40];
   logic [31:0] clock_now;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("rssi_table_oldest_replace_unit regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result({rsp_tuser, rsp_tdata[4:0], rsp_tdata[7:5], rsp_tdata[11:8]});

   task automatic send_word(func_type fn, logic [47:0] smac, logic [15:0] conn,
                            logic [47:0] dmac, logic [7:0] rssi, logic [31:0] now,
                            logic [7:0] flags, logic [5:0] alen, logic [7:0] evt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= fn;
      req_tdata <= {2'b0, evt, alen, flags, now, rssi, dmac, conn, smac};
      do @(posedge clock); while (!req_tready);
      board.note_request(fn, smac, conn, dmac, now);
   endtask

   task automatic send_random();
      int pick;
      func_type fn;
      logic [47:0] smac, dmac;
      logic [15:0] conn;
      pick = $urandom_range(99);
      if (pick < 8) fn = FUNC_ADD;
      else if (pick < 12) fn = FUNC_REMOVE;
      else if (pick < 56) fn = FUNC_RPT_CONN;
      else fn = FUNC_RPT_MAC;
      smac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
             known_smac[$urandom_range(3)];
      conn = ($urandom_range(9) == 0) ? 16'($urandom) : known_conn[$urandom_range(3)];
      dmac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
             known_dmac[$urandom_range(39)];
      if ($urandom_range(3) != 0) clock_now += $urandom_range(5);
      else clock_now = $urandom;
      send_word(fn, smac, conn, dmac, 8'($urandom), clock_now, 8'($urandom),
                6'($urandom_range(63)), 8'($urandom));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      board = new();
      board.clear();
      reset = 1; req_tvalid = 0; req_tdata = '0; req_tuser = '0; rsp_tready = 0;
      send_idle_pct = 0; recv_stall_pct = 0; clock_now = 0;
      for (int i = 0; i < 4; i++) begin
         known_smac[i] = 48'({$urandom, $urandom});
         known_conn[i] = 16'($urandom);
      end
      for (int i = 0; i < 40; i++) known_dmac[i] = 48'({$urandom, $urandom});
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_word(FUNC_RPT_CONN, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(FUNC_REMOVE, 0, 16'hffff, 0, 0, 0, 0, 0, 0);
      for (int s = 0; s < MAX_SCANNERS; s++)
         send_word(FUNC_ADD, (s == 0) ? 48'h0 : (s == 1) ? 48'hffff_ffff_ffff : 48'h100 + s,
                   (s < 2) ? 16'h7 : 16'(16'h10 + s), 0, 0, 0, 0, 0, 0);
      send_word(FUNC_ADD, 48'h0, 16'h1, 0, 0, 0, 0, 0, 0);
      send_word(FUNC_RPT_CONN, 0, 16'h7, 48'hffff_ffff_ffff, 8'h80, 32'hffff_ffff,
                8'hff, 6'd62, 8'hff);
      send_word(FUNC_RPT_MAC, 48'hffff_ffff_ffff, 0, 48'hffff_ffff_ffff, 8'h7f, 32'h0,
                8'h0, 6'd0, 8'h0);
      send_word(FUNC_RPT_MAC, 48'h102, 0, 48'h0, 8'h7f, 32'h0, 8'h55, 6'd63, 8'haa);
      send_word(FUNC_RPT_MAC, 48'h103, 0, 48'h0, 8'h01, 32'h5, 8'h0, 6'd1, 8'h0);
      send_word(FUNC_REMOVE, 0, 16'h7, 0, 0, 0, 0, 0, 0);
      send_word(FUNC_REMOVE, 0, 16'h7, 0, 0, 0, 0, 0, 0);
      send_word(FUNC_ADD, 48'h102, 16'hffff, 0, 0, 0, 0, 0, 0);
      send_word(FUNC_ADD, known_smac[0], known_conn[0], 0, 0, 0, 0, 0, 0);
      drain();
      for (int s = 0; s < MAX_SCANNERS; s++)
         send_word(FUNC_REMOVE, 0, (s < 2) ? 16'h7 : 16'(16'h10 + s), 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 4; i++)
         send_word(FUNC_ADD, known_smac[i], known_conn[i], 0, 0, 0, 0, 0, 0);

      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 70 : (ph == 4) ? 14 : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? 70 : (ph == 4) ? 14 : 0;
         for (int n = 0; n < 400; n++) send_random();
         drain();
      end

      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("rssi_table_oldest_replace_unit regression: pass");
      else
         $display("rssi_table_oldest_replace_unit regression: fail");
      $finish;
   end
endmodule
